// ===== rtl/pdlz_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdlz_pkg
// Types and constants shared by the record decoder front end, command queue
// and history back end.
// ----------------------------------------------------------------------------
package pdlz_pkg;

   localparam int DIST_W      = 11;
   localparam int LEN_W       = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0]       SPACE_CHAR   = 8'h20;
   localparam logic [7:0]       LITERAL_TOP  = 8'h7F;
   localparam logic [7:0]       SPACE_BASE   = 8'hC0;
   localparam logic [7:0]       PAIR_FLIP    = 8'h80;
   localparam logic [7:0]       COUNT_MIN    = 8'h01;
   localparam logic [7:0]       COUNT_MAX    = 8'h08;
   localparam logic [LEN_W-1:0] MIN_MATCH    = 4'd3;

   localparam logic [1:0] FAULT_NONE  = 2'd0;
   localparam logic [1:0] FAULT_DIST  = 2'd1;
   localparam logic [1:0] FAULT_TRUNC = 2'd2;

   // register index, taken from paddr[2]
   localparam logic REG_COMPRESSED_MODE = 1'b0;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_in_record;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic [1:0] fault;
      logic       last_of_run;
   } rsp_type;

   typedef enum logic [2:0] {
      CMD_LIT,
      CMD_LIT_TRUNC,
      CMD_SPACE,
      CMD_COPY,
      CMD_FAULT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [7:0]        data;
      logic [DIST_W-1:0] distance;
      logic [LEN_W-1:0]  len;
      logic [1:0]        fault;
      logic              last;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } push_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_EMIT,
      BK_SPACE,
      BK_READ,
      BK_COPY,
      BK_FAULT
   } back_state_type;

endpackage

// ===== rtl/pdlz_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdlz_front
// Accepts record bytes, tracks code state and output count, and turns each
// byte into at most one command for the back end.
// ----------------------------------------------------------------------------
module pdlz_front #(
   parameter int HISTORY_DEPTH = 2048
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              mode,
   input  logic              req_valid,
   input  pdlz_pkg::req_type req_data,
   output logic              req_ready,
   input  logic              q_full,
   output pdlz_pkg::push_type push
);

   localparam int BW = $clog2(HISTORY_DEPTH + 1);

   logic [BW-1:0] bw_ff, bw_in;
   logic [3:0]    left_ff, left_in;
   logic          pend_ff, pend_in;
   logic [5:0]    phb_ff, phb_in;

   logic                          accept;
   logic [3:0]                    add_n;
   logic [BW:0]                   bw_sum;
   logic [pdlz_pkg::DIST_W-1:0]   distance;
   logic [pdlz_pkg::LEN_W-1:0]    len;
   logic [7:0]                    c;
   logic                          last;

   assign req_ready = !q_full;
   assign accept    = req_valid && !q_full;
   assign c         = req_data.in_byte;
   assign last      = req_data.last_in_record;
   assign distance  = {phb_ff, c[7:3]};
   assign len       = {1'b0, c[2:0]} + pdlz_pkg::MIN_MATCH;
   assign bw_sum    = {1'b0, bw_ff} + (BW+1)'(add_n);

   always_comb begin
      push               = '0;
      push.cmd.data      = c;
      push.cmd.distance  = distance;
      push.cmd.len       = len;
      push.cmd.last      = last;
      push.cmd.kind      = pdlz_pkg::CMD_LIT;
      push.cmd.fault     = pdlz_pkg::FAULT_NONE;
      add_n              = 4'd0;
      left_in            = left_ff;
      pend_in            = pend_ff;
      phb_in             = phb_ff;
      bw_in              = bw_ff;
      if (accept) begin
         if (!mode) begin
            push.valid = 1'b1;
            add_n      = 4'd1;
         end else if (pend_ff) begin
            pend_in    = 1'b0;
            phb_in     = '0;
            push.valid = 1'b1;
            if (distance == '0 || BW'(distance) > bw_ff) begin
               push.cmd.kind  = pdlz_pkg::CMD_FAULT;
               push.cmd.fault = pdlz_pkg::FAULT_DIST;
            end else begin
               push.cmd.kind = pdlz_pkg::CMD_COPY;
               add_n         = len;
            end
         end else if (left_ff != '0) begin
            push.valid = 1'b1;
            add_n      = 4'd1;
            left_in    = left_ff - 4'd1;
            // record ends while literal bytes are still owed
            if (last && left_ff > 4'd1) begin
               push.cmd.kind  = pdlz_pkg::CMD_LIT_TRUNC;
               push.cmd.fault = pdlz_pkg::FAULT_TRUNC;
            end
         end else if (c >= pdlz_pkg::COUNT_MIN && c <= pdlz_pkg::COUNT_MAX) begin
            if (last) begin
               push.valid     = 1'b1;
               push.cmd.kind  = pdlz_pkg::CMD_FAULT;
               push.cmd.fault = pdlz_pkg::FAULT_TRUNC;
            end else begin
               left_in = c[3:0];
            end
         end else if (c <= pdlz_pkg::LITERAL_TOP) begin
            push.valid = 1'b1;
            add_n      = 4'd1;
         end else if (c >= pdlz_pkg::SPACE_BASE) begin
            push.valid    = 1'b1;
            push.cmd.kind = pdlz_pkg::CMD_SPACE;
            push.cmd.data = c ^ pdlz_pkg::PAIR_FLIP;
            add_n         = 4'd2;
         end else begin
            if (last) begin
               push.valid     = 1'b1;
               push.cmd.kind  = pdlz_pkg::CMD_FAULT;
               push.cmd.fault = pdlz_pkg::FAULT_TRUNC;
            end else begin
               pend_in = 1'b1;
               phb_in  = c[5:0];
            end
         end

         // saturating count of bytes this record has produced
         if (bw_sum >= (BW+1)'(HISTORY_DEPTH)) begin
            bw_in = BW'(HISTORY_DEPTH);
         end else begin
            bw_in = bw_sum[BW-1:0];
         end

         if (last) begin
            bw_in   = '0;
            left_in = '0;
            pend_in = 1'b0;
            phb_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bw_ff   <= '0;
         left_ff <= '0;
         pend_ff <= 1'b0;
         phb_ff  <= '0;
      end else begin
         bw_ff   <= bw_in;
         left_ff <= left_in;
         pend_ff <= pend_in;
         phb_ff  <= phb_in;
      end
   end

endmodule

// ===== rtl/pdlz_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdlz_queue
// Small command FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module pdlz_queue (
   input  logic               clock,
   input  logic               reset,
   input  pdlz_pkg::push_type push,
   input  logic               pop,
   output pdlz_pkg::cmd_type  head,
   output logic               empty,
   output logic               full
);

   pdlz_pkg::cmd_type entry_ff [pdlz_pkg::QUEUE_DEPTH];

   logic [pdlz_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pdlz_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pdlz_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                        do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == pdlz_pkg::QCNT_W'(pdlz_pkg::QUEUE_DEPTH));
   assign do_push = push.valid && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == pdlz_pkg::QPTR_W'(pdlz_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == pdlz_pkg::QPTR_W'(pdlz_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.cmd;
      end
   end

endmodule

// ===== rtl/pdlz_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdlz_back
// Carries out queued commands: emits bytes into the output register, keeps
// the history memory and its write pointer, and runs back-reference copies.
// ----------------------------------------------------------------------------
module pdlz_back #(
   parameter int HISTORY_DEPTH = 2048
) (
   input  logic              clock,
   input  logic              reset,
   input  pdlz_pkg::cmd_type q_head,
   input  logic              q_empty,
   output logic              pop,
   output logic              rsp_valid,
   output pdlz_pkg::rsp_type rsp_data,
   input  logic              rsp_ready
);

   localparam int AW = $clog2(HISTORY_DEPTH);

   logic [7:0] hist_mem [HISTORY_DEPTH];

   pdlz_pkg::back_state_type state_ff, state_in;
   pdlz_pkg::cmd_type        cmd_ff, cmd_in;
   logic [pdlz_pkg::LEN_W-1:0] len_ff, len_in;
   logic [AW-1:0]            wp_ff, wp_in;
   logic [7:0]               rd_data_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   pdlz_pkg::rsp_type        rsp_data_ff, rsp_data_in;

   logic          out_free;
   logic          emit, emit_data, emit_final;
   logic [7:0]    emit_byte;
   logic          mem_we, rd_en;
   logic [AW-1:0] dist_ext, rd_addr, wp_next;
   logic [AW:0]   wrap_sum;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign dist_ext = AW'(cmd_ff.distance);
   assign wrap_sum = {1'b0, wp_ff} + (AW+1)'(HISTORY_DEPTH) - {1'b0, dist_ext};
   assign rd_addr  = (wp_ff >= dist_ext) ? (wp_ff - dist_ext) : wrap_sum[AW-1:0];
   assign wp_next  = (wp_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_ff + 1'b1;

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      len_in     = len_ff;
      pop        = 1'b0;
      rd_en      = 1'b0;
      emit       = 1'b0;
      emit_data  = 1'b1;
      emit_final = 1'b1;
      emit_byte  = cmd_ff.data;
      unique case (state_ff)
         pdlz_pkg::BK_IDLE: begin
            if (!q_empty) begin
               pop    = 1'b1;
               cmd_in = q_head;
               len_in = q_head.len;
               unique case (q_head.kind)
                  pdlz_pkg::CMD_LIT, pdlz_pkg::CMD_LIT_TRUNC: state_in = pdlz_pkg::BK_EMIT;
                  pdlz_pkg::CMD_SPACE: state_in = pdlz_pkg::BK_SPACE;
                  pdlz_pkg::CMD_COPY:  state_in = pdlz_pkg::BK_READ;
                  default:             state_in = pdlz_pkg::BK_FAULT;
               endcase
            end
         end
         pdlz_pkg::BK_EMIT: begin
            emit_final = (cmd_ff.kind != pdlz_pkg::CMD_LIT_TRUNC);
            if (out_free) begin
               emit     = 1'b1;
               state_in = emit_final ? pdlz_pkg::BK_IDLE : pdlz_pkg::BK_FAULT;
            end
         end
         pdlz_pkg::BK_SPACE: begin
            emit_byte  = pdlz_pkg::SPACE_CHAR;
            emit_final = 1'b0;
            if (out_free) begin
               emit     = 1'b1;
               state_in = pdlz_pkg::BK_EMIT;
            end
         end
         pdlz_pkg::BK_READ: begin
            // history is read in BK_READ, into rd_data_ff, ahead of the emit in BK_COPY that writes it back
            rd_en    = 1'b1;
            state_in = pdlz_pkg::BK_COPY;
         end
         pdlz_pkg::BK_COPY: begin
            emit_byte  = rd_data_ff;
            emit_final = (len_ff == pdlz_pkg::LEN_W'(1));
            if (out_free) begin
               emit     = 1'b1;
               len_in   = len_ff - 1'b1;
               state_in = emit_final ? pdlz_pkg::BK_IDLE : pdlz_pkg::BK_READ;
            end
         end
         pdlz_pkg::BK_FAULT: begin
            emit_data = 1'b0;
            if (out_free) begin
               emit     = 1'b1;
               state_in = pdlz_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = pdlz_pkg::BK_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      wp_in        = wp_ff;
      if (emit) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.out_byte    = emit_data ? emit_byte : 8'h00;
         rsp_data_in.byte_valid  = emit_data;
         rsp_data_in.fault       = emit_data ? pdlz_pkg::FAULT_NONE : cmd_ff.fault;
         rsp_data_in.last_of_run = emit_final;
         if (emit_data) begin
            mem_we = 1'b1;
            wp_in  = wp_next;
         end
         if (emit_final && cmd_ff.last) begin
            wp_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pdlz_pkg::BK_IDLE;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      len_ff      <= len_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[wp_ff] <= emit_byte;
      end
      if (rd_en) begin
         rd_data_ff <= hist_mem[rd_addr];
      end
   end

endmodule

// ===== rtl/palmdoc_lz77_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palmdoc_lz77_decoder
// Byte-stream decoder for LZ77-style compressed text records.
// ----------------------------------------------------------------------------
// One compressed byte is taken per word on req_; decoded bytes and fault words
// leave one per word on rsp_. The front end classifies a byte in its accept
// cycle and queues at most one command (four deep); the back end dispatches
// each command from idle, then emits its literal or fault word, and for each
// copied byte first does a registered read of the single history memory, whose
// result is then emitted and written back. The history needs no clearing after
// reset.
module palmdoc_lz77_decoder #(
   parameter int HISTORY_DEPTH = 2048
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pdlz_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pdlz_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic mode_ff, mode_in;
   logic csr_wr;

   pdlz_pkg::push_type push;
   pdlz_pkg::cmd_type  q_head;
   logic               q_empty, q_full, pop;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == pdlz_pkg::REG_COMPRESSED_MODE) ?
                       {31'b0, mode_ff} : 32'b0;

   always_comb begin
      mode_in = mode_ff;
      if (csr_wr && csr_paddr[2] == pdlz_pkg::REG_COMPRESSED_MODE) begin
         mode_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b1;
      end else begin
         mode_ff <= mode_in;
      end
   end

   pdlz_front #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_ready (req_ready),
      .q_full    (q_full),
      .push      (push)
   );

   pdlz_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (q_head),
      .empty (q_empty),
      .full  (q_full)
   );

   pdlz_back #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .q_empty   (q_empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_ready (rsp_ready)
   );

   // back end only dispatches real commands
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_empty)
      else $error("command popped from empty queue");

   // a distance fault is a lone word and ends its run
   a_dist_fault_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.fault == pdlz_pkg::FAULT_DIST) |->
      (rsp_data.last_of_run && !rsp_data.byte_valid && rsp_data.out_byte == 8'h00))
      else $error("malformed distance fault word");

   // a data word never carries a fault code
   a_data_no_fault: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.byte_valid) |-> (rsp_data.fault == pdlz_pkg::FAULT_NONE))
      else $error("data word with fault code");

   a_mode_write: assert property (@(posedge clock) disable iff (reset)
      (csr_wr && csr_paddr[2] == pdlz_pkg::REG_COMPRESSED_MODE) |=>
      (mode_ff == $past(csr_pwdata[0])))
      else $error("mode register write lost");

endmodule

// ===== sim/pdlz_decode_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdlz_decode_checker
// Watches the code-byte, text and register ports of the record decoder. It
// keeps its own copy of the history and record state, predicts the text words
// each accepted code byte causes, and compares every accepted text word, field
// by field, with the oldest prediction. It hands the mismatch count and the
// number of predicted words still outstanding to the testbench top.
// ----------------------------------------------------------------------------
module pdlz_decode_checker #(
   parameter int HISTORY_DEPTH = 2048
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  pdlz_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  pdlz_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic              csr_pready,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output int                mismatch_count,
   output int                words_owed
);

   localparam int HIST_AW   = $clog2(HISTORY_DEPTH);
   localparam int PRINT_CAP = 40;

   logic [7:0]         history_mem [HISTORY_DEPTH];
   logic [HIST_AW-1:0] write_ptr;
   logic [HIST_AW:0]   text_count;
   logic [3:0]         literals_owed;
   logic               pair_open;
   logic [5:0]         pair_top;
   logic               decode_on;
   pdlz_pkg::rsp_type  expected_text [$];

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      if (mismatch_count < PRINT_CAP)
         $display("%0t mismatch: %s got %0h expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic emit_text(input logic [7:0] b);
      history_mem[write_ptr] = b;
      write_ptr++;
      if (text_count < HISTORY_DEPTH)
         text_count++;
      expected_text.push_back('{out_byte: b, byte_valid: 1'b1,
                                fault: pdlz_pkg::FAULT_NONE, last_of_run: 1'b0});
   endtask

   task automatic emit_fault(input logic [1:0] code);
      expected_text.push_back('{out_byte: 8'h00, byte_valid: 1'b0, fault: code,
                                last_of_run: 1'b0});
   endtask

   task automatic decode_code_byte(input pdlz_pkg::req_type w);
      int                            first;
      logic [13:0]                   pair_word;
      logic [pdlz_pkg::DIST_W-1:0]   distance;
      logic [pdlz_pkg::LEN_W-1:0]    len;
      logic [HIST_AW-1:0]            src;
      pdlz_pkg::rsp_type             tail;
      first = expected_text.size();
      if (!decode_on) begin
         // pass-through leaves pending codes alone
         emit_text(w.in_byte);
      end else if (pair_open) begin
         pair_word = {pair_top, w.in_byte};
         distance  = pair_word[13:3];
         len       = {1'b0, pair_word[2:0]} + pdlz_pkg::MIN_MATCH;
         pair_open = 1'b0;
         pair_top  = '0;
         if (distance == 0 || distance > text_count) begin
            emit_fault(pdlz_pkg::FAULT_DIST);
         end else begin
            // each copied byte is written back before the next read
            for (int i = 0; i < len; i++) begin
               src = write_ptr - distance;
               emit_text(history_mem[src]);
            end
         end
      end else if (literals_owed != 0) begin
         emit_text(w.in_byte);
         literals_owed--;
         if (w.last_in_record && literals_owed != 0)
            emit_fault(pdlz_pkg::FAULT_TRUNC);
      end else if (w.in_byte >= pdlz_pkg::COUNT_MIN && w.in_byte <= pdlz_pkg::COUNT_MAX) begin
         if (w.last_in_record)
            emit_fault(pdlz_pkg::FAULT_TRUNC);
         else
            literals_owed = w.in_byte[3:0];
      end else if (w.in_byte <= pdlz_pkg::LITERAL_TOP) begin
         emit_text(w.in_byte);
      end else if (w.in_byte >= pdlz_pkg::SPACE_BASE) begin
         emit_text(pdlz_pkg::SPACE_CHAR);
         emit_text(w.in_byte ^ pdlz_pkg::PAIR_FLIP);
      end else if (w.last_in_record) begin
         emit_fault(pdlz_pkg::FAULT_TRUNC);
      end else begin
         pair_open = 1'b1;
         pair_top  = w.in_byte[5:0];
      end

      if (expected_text.size() > first) begin
         tail = expected_text.pop_back();
         tail.last_of_run = 1'b1;
         expected_text.push_back(tail);
      end

      if (w.last_in_record) begin
         write_ptr     = '0;
         text_count    = '0;
         literals_owed = '0;
         pair_open     = 1'b0;
         pair_top      = '0;
      end
   endtask

   always @(posedge clock) begin
      pdlz_pkg::rsp_type want;
      if (reset) begin
         write_ptr     = '0;
         text_count    = '0;
         literals_owed = '0;
         pair_open     = 1'b0;
         pair_top      = '0;
         decode_on     = 1'b1;
         expected_text.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr[2] == pdlz_pkg::REG_COMPRESSED_MODE)
            decode_on = csr_pwdata[0];
         // compare before predicting: a word leaving now cannot stem from
         // a code byte taken at this same edge
         if (rsp_valid && rsp_ready) begin
            if (expected_text.size() == 0) begin
               report_mismatch("unexpected word, out_byte", rsp_data.out_byte, 8'h00);
            end else begin
               want = expected_text.pop_front();
               if (rsp_data.out_byte != want.out_byte)
                  report_mismatch("out_byte", rsp_data.out_byte, want.out_byte);
               if (rsp_data.byte_valid != want.byte_valid)
                  report_mismatch("byte_valid", 8'(rsp_data.byte_valid),
                                  8'(want.byte_valid));
               if (rsp_data.fault != want.fault)
                  report_mismatch("fault", 8'(rsp_data.fault), 8'(want.fault));
               if (rsp_data.last_of_run != want.last_of_run)
                  report_mismatch("last_of_run", 8'(rsp_data.last_of_run),
                                  8'(want.last_of_run));
            end
         end
         if (req_valid && req_ready)
            decode_code_byte(req_data);
      end
      words_owed = expected_text.size();
   end

endmodule

// ===== sim/palmdoc_lz77_decoder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palmdoc_lz77_decoder_test
// Drives compressed records into the decoder: a directed set of codes, then
// random well-formed records with some noise and cut-off endings, in both
// decode and pass-through mode, under random idling on both ports and one
// long stall of the text port. The checker beside the block does the
// prediction and comparison; this module only makes stimulus and decides.
// ----------------------------------------------------------------------------
module palmdoc_lz77_decoder_test;

   localparam int         HOLD_CYCLES  = 300;
   localparam int         DRAIN_CYCLES = 64;
   localparam logic [2:0] MODE_ADDR    = {pdlz_pkg::REG_COMPRESSED_MODE, 2'b00};

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   pdlz_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   pdlz_pkg::rsp_type rsp_data;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [2:0]        csr_paddr;
   logic [31:0]       csr_pwdata;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   int mismatch_count;
   int words_owed;
   int items_sent;
   bit steady;
   bit rx_hold;

   palmdoc_lz77_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   pdlz_decode_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .mismatch_count (mismatch_count),
      .words_owed     (words_owed)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // text port: random back-pressure, with one long hold-off on request
   initial begin
      int held;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rx_hold) begin
            rsp_ready <= 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++)
               @(posedge clock);
            rx_hold = 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(0, 99) >= 29);
         end
      end
   end

   task automatic offer_byte(input logic [7:0] code, input logic last);
      while (!steady && $urandom_range(0, 99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_data  <= '{in_byte: code, last_in_record: last};
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic write_mode(input logic value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= MODE_ADDR;
      csr_pwdata  <= {31'b0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_owed != 0)
         @(posedge clock);
      // codes that give no word may still sit in the block
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one record of random tokens; made tracks the text written so far so
   // that most back-references land inside it
   task automatic send_record(input int tokens, input bit copy_heavy);
      logic [7:0] code_q [$];
      int         made;
      int         pick;
      int         n;
      int         span;
      int         distance;
      int         len;
      int         r;
      made = 0;
      for (int t = 0; t < tokens; t++) begin
         pick = $urandom_range(0, 99);
         if (copy_heavy && pick < 75)
            pick = 70;
         if (pick < 35 || (pick >= 65 && pick < 95 && made == 0)) begin
            code_q.push_back(($urandom_range(0, 19) == 0) ? 8'h00 : 8'($urandom_range(9, 127)));
            made++;
         end else if (pick < 50) begin
            n = $urandom_range(1, 8);
            code_q.push_back(8'(n));
            repeat (n) code_q.push_back(8'($urandom_range(0, 255)));
            made += n;
         end else if (pick < 65) begin
            code_q.push_back(8'($urandom_range(8'hC0, 8'hFF)));
            made += 2;
         end else if (pick < 95) begin
            span = (made > 2047) ? 2047 : made;
            r    = $urandom_range(0, 19);
            if (r == 0)
               distance = 0;
            else if (r == 1)
               distance = (span < 2047) ? span + 1 : 0;
            else if (r < 11)
               distance = $urandom_range(1, (span < 8) ? span : 8);
            else
               distance = $urandom_range(1, span);
            len = copy_heavy ? 10 : $urandom_range(3, 10);
            code_q.push_back(8'h80 | 8'(distance >> 5));
            code_q.push_back(8'((distance << 3) | (len - 3)));
            if (distance >= 1 && distance <= made)
               made += len;
         end else begin
            code_q.push_back(8'($urandom_range(0, 255)));
         end
         if (made > 2048)
            made = 2048;
      end
      // sometimes the record ends in the middle of a code
      if ($urandom_range(0, 99) < 15) begin
         case ($urandom_range(0, 2))
            0: code_q.push_back(8'($urandom_range(1, 8)));
            1: code_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
            default: begin
               code_q.push_back(8'h05);
               code_q.push_back(8'h61);
            end
         endcase
      end
      foreach (code_q[i])
         offer_byte(code_q[i], i == code_q.size() - 1);
   endtask

   initial begin
      int start;
      bit hold_done;
      bit paused;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      steady      = 1'b0;
      rx_hold     = 1'b0;
      items_sent  = 0;
      hold_done   = 1'b0;
      paused      = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_mode(1'b1);
      // plain literals and space codes at their limits
      offer_byte(8'h00, 1'b0);
      offer_byte(8'h7F, 1'b0);
      offer_byte(8'hC0, 1'b0);
      offer_byte(8'hFF, 1'b0);
      // count code followed by raw bytes that look like codes
      offer_byte(8'h03, 1'b0);
      offer_byte(8'h80, 1'b0);
      offer_byte(8'hFF, 1'b0);
      offer_byte(8'h01, 1'b0);
      // zero distance, distance 1 at full length, distance past the text
      offer_byte(8'h80, 1'b0);
      offer_byte(8'h07, 1'b0);
      offer_byte(8'h80, 1'b0);
      offer_byte(8'h0F, 1'b0);
      offer_byte(8'hBF, 1'b0);
      offer_byte(8'hFF, 1'b0);
      // count code cut off at record end
      offer_byte(8'h08, 1'b1);
      // pair cut off at record end
      offer_byte(8'h85, 1'b1);
      // overlapping copy, then a count left pending across a mode change
      offer_byte(8'h41, 1'b0);
      offer_byte(8'h42, 1'b0);
      offer_byte(8'h80, 1'b0);
      offer_byte(8'h13, 1'b0);
      offer_byte(8'h04, 1'b0);
      wait_drained();
      write_mode(1'b0);
      offer_byte(8'h85, 1'b0);
      offer_byte(8'h03, 1'b0);
      wait_drained();
      write_mode(1'b1);
      // record ends while raw bytes are still owed
      offer_byte(8'h61, 1'b0);
      offer_byte(8'h62, 1'b0);
      offer_byte(8'h63, 1'b1);
      wait_drained();

      start = items_sent;
      while (items_sent - start < 140) begin
         if (!hold_done && items_sent - start > 40) begin
            rx_hold   = 1'b1;
            hold_done = 1'b1;
         end
         steady = (items_sent - start > 80) && (items_sent - start < 130);
         send_record($urandom_range(2, 14), 1'b0);
      end
      steady = 1'b0;
      wait_drained();

      write_mode(1'b0);
      repeat (40) offer_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      wait_drained();

      write_mode(1'b1);
      send_record(40, 1'b1);
      start = items_sent;
      while (items_sent - start < 120) begin
         if (!paused && items_sent - start > 60) begin
            wait_drained();
            paused = 1'b1;
         end
         send_record($urandom_range(2, 14), 1'b0);
      end
      wait_drained();

      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
